// ===== sv/g2h_pkg.sv =====
// ----------------------------------------------------------------------------
// Gregorian to Hebrew date conversion package
// Shared constants, state encoding and controller/datapath command types.
// ----------------------------------------------------------------------------
package g2h_pkg;

	localparam int unsigned YearLo      = 1583;
	localparam int unsigned YearHi      = 4359;
	localparam int unsigned AmOffset    = 3744;
	localparam int unsigned DayBias     = 5968;
	localparam int unsigned PartsHour   = 1080;
	localparam int unsigned PartsDay    = 24 * PartsHour;
	localparam int unsigned PartsWeek   = 7 * PartsDay;
	localparam int unsigned PartsLun    = PartsDay + 12 * PartsHour + 793;
	localparam int unsigned MoladEpoch  = 7 * PartsHour + 779;
	localparam int unsigned GataradLim  = 15 * PartsHour + 204;
	localparam int unsigned BetutakLim  = 21 * PartsHour + 589;
	localparam int unsigned TailDays    = 236;
	localparam int unsigned HeadBase    = 114;
	localparam int unsigned HalfMonths  = 59;
	localparam int unsigned CycleYears  = 19;

	// Reciprocals for division by small constants. Each one is exact over the
	// range of values that reaches it; the shift is given beside it.
	localparam int unsigned MdayRecip   = 367 * 2731;  // 367 * m / 12, shift 15
	localparam int unsigned CentRecip   = 1311;        // / 100, shift 17
	localparam int unsigned Div19Recip  = 55189;       // / 19, shift 20
	localparam int unsigned Div7Recip   = 149797;      // / 7, shift 20
	localparam int unsigned Day7Recip   = 2396746;     // / 7, shift 24
	localparam int unsigned Div405Recip = 10604858;    // / 405, shift 32

	// Day counts and molad parts fit comfortably in these widths.
	localparam int unsigned DW = 22;   // day count
	localparam int unsigned PW = 30;   // molad fraction in parts
	localparam int unsigned MW = 17;   // month count
	localparam int unsigned YW = 13;   // year

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DAYS,
		ST_ED_A,
		ST_ED_B,
		ST_ED_C,
		ST_ED_D,
		ST_ED_E,
		ST_CHECK,
		ST_DIVLD,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} g2h_state_t;

	typedef struct packed {
		logic load;      // capture inputs
		logic days;      // compute day count
		logic ed_a;      // elapsed-days steps
		logic ed_b;
		logic ed_c;
		logic ed_d;
		logic ed_e;
		logic advance;   // step on to the next year
		logic div_ld;    // set up month divider
		logic div_step;  // one divider bit
		logic fin;       // finish result
	} g2h_cmd_t;

	typedef struct packed {
		logic second;    // elapsed-days result is the "next" year
		logic advance;   // day count reached next year start
		logic div_done;
	} g2h_stat_t;

endpackage

// ===== sv/gregorian_to_hebrew_date.sv =====
// ----------------------------------------------------------------------------
// Gregorian to Hebrew date converter
// Runs a day count, two elapsed-days passes of five steps each and a month
// divider; each year advance adds one more elapsed-days pass, and the
// controller takes at most four advances for any input.
// A new conversion is accepted only after the previous one returns to idle.
// Reset clears the controller only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module gregorian_to_hebrew_date (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic [12:0]       gregorian_year,
	input  logic [3:0]        gregorian_month,
	input  logic [4:0]        gregorian_day,
	output logic [12:0]       hebrew_year,
	output logic [3:0]        hebrew_month,
	output logic [4:0]        hebrew_day,
	output logic [2:0]        week_day,
	output logic signed [1:0] year_kind
);
	import g2h_pkg::*;

	g2h_cmd_t  cmd;
	g2h_stat_t stat;

	g2h_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .stat(stat)
	);

	g2h_dp u_dp (
		.clk(clk), .gregorian_year(gregorian_year), .gregorian_month(gregorian_month),
		.gregorian_day(gregorian_day), .cmd(cmd), .stat(stat),
		.hebrew_year(hebrew_year), .hebrew_month(hebrew_month), .hebrew_day(hebrew_day),
		.week_day(week_day), .year_kind(year_kind)
	);

endmodule

// ===== sv/g2h_ctrl.sv =====
// ----------------------------------------------------------------------------
// Gregorian to Hebrew controller
// Sequences the day count, year refinement and month division.
// ----------------------------------------------------------------------------
module g2h_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output g2h_pkg::g2h_cmd_t  cmd,
	input  g2h_pkg::g2h_stat_t stat
);
	import g2h_pkg::*;

	g2h_state_t state_q, state_d;
	logic [2:0] steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			steps_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DAYS) steps_q <= '0;
			else if (state_q == ST_CHECK && stat.second && stat.advance)
				steps_q <= steps_q + 3'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_DAYS;
			ST_DAYS:  state_d = ST_ED_A;
			ST_ED_A:  state_d = ST_ED_B;
			ST_ED_B:  state_d = ST_ED_C;
			ST_ED_C:  state_d = ST_ED_D;
			ST_ED_D:  state_d = ST_ED_E;
			ST_ED_E:  state_d = stat.second ? ST_CHECK : ST_ED_A;
			ST_CHECK: begin
				if (stat.advance && steps_q != 3'd4) state_d = ST_ED_A;
				else state_d = ST_DIVLD;
			end
			ST_DIVLD: state_d = ST_DIV;
			ST_DIV:   if (stat.div_done) state_d = ST_FIN;
			ST_FIN:   state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		busy     = (state_q != ST_IDLE);
		done     = (state_q == ST_DONE);
		case (state_q)
			ST_IDLE:  cmd.load = start;
			ST_DAYS:  cmd.days = 1'b1;
			ST_ED_A:  cmd.ed_a = 1'b1;
			ST_ED_B:  cmd.ed_b = 1'b1;
			ST_ED_C:  cmd.ed_c = 1'b1;
			ST_ED_D:  cmd.ed_d = 1'b1;
			ST_ED_E:  cmd.ed_e = 1'b1;
			ST_CHECK: cmd.advance = stat.advance && steps_q != 3'd4;
			ST_DIVLD: cmd.div_ld = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_FIN:   cmd.fin = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

// ===== sv/g2h_dp.sv =====
// ----------------------------------------------------------------------------
// Gregorian to Hebrew datapath
// Day count, elapsed-days rule, refinement and month/day split.
// ----------------------------------------------------------------------------
module g2h_dp (
	input  logic               clk,
	input  logic [12:0]        gregorian_year,
	input  logic [3:0]         gregorian_month,
	input  logic [4:0]         gregorian_day,
	input  g2h_pkg::g2h_cmd_t  cmd,
	output g2h_pkg::g2h_stat_t stat,
	output logic [12:0]        hebrew_year,
	output logic [3:0]         hebrew_month,
	output logic [4:0]         hebrew_day,
	output logic [2:0]         week_day,
	output logic signed [1:0]  year_kind
);
	import g2h_pkg::*;

	logic [YW-1:0] y_q, ey_q;
	logic [3:0]    m_q;
	logic [4:0]    d_in_q;
	logic [DW-1:0] d_q, start_q, next_q, ed_days_q;
	logic          second_q;
	logic [MW-1:0] months_q;
	logic [4:0]    leap_q;
	logic [PW-1:0] parts_q;
	logic [PW-1:0] pmod_q;
	logic [14:0]   pq_q;
	logic [2:0]    wday_q;
	logic [2:0]    wk_q;
	logic [8:0]    mday_q;
	logic [5:0]    cent_q;

	// divider: numerator / denominator, restoring, 10 bits
	logic [9:0]    num_q, quo_q;
	logic [8:0]    den_q, rem_q;
	logic [3:0]    cnt_q;
	logic          tail_q;
	logic [DW-1:0] dd_q;
	logic [8:0]    len_q;
	logic [2:0]    kind_q;

	// input clamp and March-based conversion
	logic [YW-1:0] yc, ym;
	logic [3:0]    mc, mm;
	logic [4:0]    dc;
	always_comb begin
		yc = gregorian_year;
		if (yc < YW'(YearLo)) yc = YW'(YearLo);
		if (yc > YW'(YearHi)) yc = YW'(YearHi);
		mc = gregorian_month;
		if (mc < 4'd1)  mc = 4'd1;
		if (mc > 4'd12) mc = 4'd12;
		dc = (gregorian_day == 5'd0) ? 5'd1 : gregorian_day;
		if (mc <= 4'd2) begin
			mm = mc + 4'd10;
			ym = yc - YW'(1);
		end else begin
			mm = mc - 4'd2;
			ym = yc;
		end
	end

	logic [DW-1:0] dcount;
	assign dcount = DW'(d_in_q) + DW'(365) * DW'(y_q) + DW'(y_q >> 2) + DW'(mday_q)
		+ DW'(DayBias + 2) + DW'(cent_q >> 2) - DW'(cent_q);

	// The weekday of the day count is taken modulo 7 by a reciprocal.
	logic [DW-1:0] dp1;
	logic [47:0]   wkp;
	assign dp1 = d_q + DW'(1);
	assign wkp = 48'(dp1) * 48'(Day7Recip);

	// elapsed-days steps
	logic [YW-1:0] eyr;
	logic [16:0]   leapv;
	logic [31:0]   q19p;
	logic [10:0]   lq;
	assign eyr   = second_q ? ey_q + YW'(1) : ey_q;
	assign leapv = 17'(eyr) * 17'd7 + 17'd1;
	assign q19p  = 32'(leapv) * 32'(Div19Recip);
	assign lq    = 11'(q19p >> 20);

	// Whole days in the molad fraction: divide by 64 and then by 405.
	logic [47:0]   pqp;
	assign pqp = 48'(parts_q >> 6) * 48'(Div405Recip);

	// The molad weekday is (months + whole days) modulo 7.
	logic [MW-1:0] wsum;
	logic [39:0]   wdp;
	assign wsum = months_q + MW'(pq_q);
	assign wdp  = 40'(wsum) * 40'(Div7Recip);

	logic [2:0]    wd_adj;
	logic [DW-1:0] days_adj;
	logic          molz;
	always_comb begin
		molz = ((leap_q < 5'd12) && (wday_q == 3'd3) && (pmod_q >= PW'(GataradLim))) ||
		       ((leap_q < 5'd7)  && (wday_q == 3'd2) && (pmod_q >= PW'(BetutakLim)));
		wd_adj   = molz ? wday_q + 3'd1 : wday_q;
		days_adj = molz ? ed_days_q + DW'(1) : ed_days_q;
		if (wd_adj == 3'd1 || wd_adj == 3'd4 || wd_adj == 3'd6)
			days_adj = days_adj + DW'(1);
	end

	logic [DW-1:0] len_full, d_rel;
	logic [2:0]    kind_full;
	assign len_full = next_q - start_q;
	assign d_rel    = (d_q >= start_q) ? d_q - start_q : '0;
	// Year lengths are 353 to 355 or 383 to 385 days, so the last digit is an
	// offset from 350 or from 380.
	assign kind_full = (len_full < DW'(370)) ? 3'(len_full - DW'(350))
		: 3'(len_full - DW'(380));

	assign stat.second   = second_q;
	assign stat.advance  = (d_q >= next_q);
	assign stat.div_done = (cnt_q == 4'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q    <= ym;
			m_q    <= mm;
			d_in_q <= dc;
		end
		if (cmd.days) begin
			mday_q   <= 9'((24'(m_q) * 24'(MdayRecip)) >> 15);
			cent_q   <= 6'((24'(y_q) * 24'(CentRecip)) >> 17);
			ey_q     <= y_q + YW'(16);
			second_q <= 1'b0;
		end
		if (cmd.ed_a) begin
			d_q      <= dcount;
			months_q <= MW'(eyr) * MW'(12) + MW'(lq);
			leap_q   <= 5'(leapv - 17'(lq) * 17'd19);
		end
		if (cmd.ed_b) begin
			parts_q <= PW'(months_q) * PW'(PartsLun - PartsDay) + PW'(MoladEpoch);
			wk_q    <= 3'(dp1 - DW'(wkp >> 24) * DW'(7));
		end
		if (cmd.ed_c)
			pq_q <= 15'(pqp >> 32);
		if (cmd.ed_d) begin
			ed_days_q <= DW'(months_q) * DW'(29) + DW'(pq_q) - DW'(2);
			pmod_q    <= parts_q - PW'(pq_q) * PW'(PartsDay);
			wday_q    <= 3'(wsum - MW'(wdp >> 20) * MW'(7));
		end
		if (cmd.ed_e) begin
			if (second_q) next_q <= days_adj;
			else          start_q <= days_adj;
			second_q <= 1'b1;
		end
		if (cmd.advance) begin
			// advancing one year: old next becomes start
			start_q <= next_q;
			ey_q    <= ey_q + YW'(1);
		end
		if (cmd.div_ld) begin
			len_q  <= 9'(len_full);
			kind_q <= kind_full;
			dd_q   <= d_rel;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= 4'd10;
			if (d_rel >= len_full - DW'(TailDays)) begin
				tail_q <= 1'b1;
				num_q  <= 10'((d_rel - (len_full - DW'(TailDays))) << 1);
				den_q  <= 9'(HalfMonths);
			end else begin
				tail_q <= 1'b0;
				num_q  <= 10'(d_rel << 2);
				den_q  <= 9'(HeadBase) + 9'(kind_full);
			end
		end
		if (cmd.div_step && cnt_q != 4'd0) begin
			if ({rem_q[7:0], num_q[9]} >= den_q) begin
				rem_q <= {rem_q[7:0], num_q[9]} - den_q;
				quo_q <= {quo_q[8:0], 1'b1};
			end else begin
				rem_q <= {rem_q[7:0], num_q[9]};
				quo_q <= {quo_q[8:0], 1'b0};
			end
			num_q <= {num_q[8:0], 1'b0};
			cnt_q <= cnt_q - 4'd1;
		end
		if (cmd.fin) begin
			hebrew_year <= ey_q + YW'(AmOffset);
			week_day    <= wk_q;
			year_kind   <= 2'(kind_q + 3'd4);
			if (tail_q) begin
				hebrew_day <= 5'(dd_q - DW'(len_q - 9'(TailDays))
					- DW'((quo_q * 10'(HalfMonths) + 10'd1) >> 1) + DW'(1));
				if (len_q > 9'd365 && quo_q + 10'd4 <= 10'd5)
					hebrew_month <= 4'(quo_q + 10'd13);
				else
					hebrew_month <= 4'(quo_q + 10'd5);
			end else begin
				// The divisor register still holds the head month length in quarter days.
				hebrew_day   <= 5'(dd_q - DW'((quo_q * 10'(den_q) + 10'd3) >> 2)
					+ DW'(1));
				hebrew_month <= 4'(quo_q + 10'd1);
			end
		end
	end

endmodule
